// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files of the escape decoder.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BED_ASSERT_HOLD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bed assertion failed");

// Check that a condition on one edge is followed by a property on the next.
`define BED_ASSERT_AFTER(lbl, clk, cond, prop) \
   lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("bed assertion failed");

`endif

// ----- src/bed_pkg.sv -----
// Shared types, constants and the escape table for the escape decoder.
// No dependencies; imported by the decode, queue and top-level modules.
package bed_pkg;

   // Result queue sizing: one item writes at most RES_MAX words
   localparam int RES_MAX     = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_STOP      = 8'h63;
   localparam logic [7:0] HEX_LOWER_BIAS = 8'd87;
   localparam logic [7:0] HEX_UPPER_BIAS = 8'd55;
   localparam logic [1:0] OCT_DIGITS_ARG = 2'd3;
   localparam logic [1:0] OCT_DIGITS_FMT = 2'd2;

   typedef enum logic [2:0] {
      PH_TEXT,
      PH_ESC,
      PH_OCT,
      PH_HEX0,
      PH_HEX1,
      PH_DROP
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       end_of_string;
      logic       stop_all;
      logic       bad_hex;
   } rsp_word_type;

   typedef struct packed {
      phase_type  phase;
      logic [8:0] accum_value;
      logic [1:0] digits_left;
   } dec_state_type;

   typedef struct packed {
      rsp_word_type [RES_MAX-1:0] words;
      logic [1:0]                 count;
   } dec_out_type;

   // Single-character escapes: bit 8 flags a hit, bits 7:0 give the value
   function automatic logic [8:0] esc_map(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         CH_BACKSLASH: r = {1'b1, 8'd92};
         8'h61:        r = {1'b1, 8'd7};
         8'h62:        r = {1'b1, 8'd8};
         8'h66:        r = {1'b1, 8'd12};
         8'h6E:        r = {1'b1, 8'd10};
         8'h72:        r = {1'b1, 8'd13};
         8'h74:        r = {1'b1, 8'd9};
         8'h76:        r = {1'b1, 8'd11};
         default:      r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- src/bed_req_if.sv -----
// Input channel of the escape decoder: one raw byte per word.
// No dependencies.
interface bed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ----- src/bed_rsp_if.sv -----
// Result channel of the escape decoder: at most one decoded byte per word.
// No dependencies.
interface bed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       run_last;
   logic       end_of_string;
   logic       stop_all;
   logic       bad_hex;

   modport source (output valid, output out_byte, output has_byte, output run_last,
                   output end_of_string, output stop_all, output bad_hex, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input run_last,
                   input end_of_string, input stop_all, input bad_hex, output ready);
endinterface

// ----- src/bed_decode.sv -----
// Combinational step of the escape decoder: next state and up to three words.
// Depends on bed_pkg.
module bed_decode (
   input  bed_pkg::dec_state_type state,
   input  logic                   argument_mode,
   input  logic [7:0]             in_byte,
   input  logic                   is_last,
   output bed_pkg::dec_state_type next_state,
   output bed_pkg::dec_out_type   words
);
   import bed_pkg::*;

   function automatic rsp_word_type make_word(input logic [7:0] b, input logic has,
                                              input logic stop, input logic bad);
      rsp_word_type w;
      w               = '0;
      w.out_byte      = b;
      w.has_byte      = has;
      w.stop_all      = stop;
      w.bad_hex       = bad;
      return w;
   endfunction

   // Append a word unless the list is full
   function automatic dec_out_type add_word(input dec_out_type list, input rsp_word_type w);
      dec_out_type r;
      r = list;
      if (r.count != 2'(RES_MAX)) begin
         r.words[r.count] = w;
         r.count          = r.count + 2'd1;
      end
      return r;
   endfunction

   always_comb begin : step_proc
      phase_type   ph;
      logic [8:0]  acc;
      logic [1:0]  dl;
      dec_out_type lst;
      logic        em_req;
      logic [7:0]  em_val;
      logic        pl_req;
      logic        is_oct;
      logic        is_dec;
      logic        is_lo;
      logic        is_up;
      logic        is_hex;
      logic [3:0]  hv;
      logic [8:0]  esc;
      logic [8:0]  oct_acc;
      logic [1:0]  oct_dl;
      logic [7:0]  tail_val;

      ph     = PH_TEXT;
      acc    = state.accum_value;
      dl     = state.digits_left;
      lst    = '0;
      em_req = 1'b0;
      em_val = 8'd0;
      pl_req = 1'b0;

      // Classify the byte
      is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
      is_dec = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
      is_lo  = (in_byte >= CH_LOWER_A) && (in_byte <= CH_LOWER_F);
      is_up  = (in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_F);
      is_hex = is_dec || is_lo || is_up;
      hv     = is_dec ? in_byte[3:0]
             : is_lo  ? 4'(in_byte - HEX_LOWER_BIAS)
             :          4'(in_byte - HEX_UPPER_BIAS);
      esc    = esc_map(in_byte);
      oct_acc = {acc[5:0], in_byte[2:0]};
      oct_dl  = (dl != 2'd0) ? dl - 2'd1 : 2'd0;

      // Advance the escape state
      case (state.phase)
         PH_TEXT: begin
            pl_req = 1'b1;
         end
         PH_ESC: begin
            if (argument_mode && in_byte == CH_STOP) begin
               lst = add_word(lst, make_word(8'd0, 1'b0, 1'b1, 1'b0));
               ph  = PH_DROP;
            end else if (argument_mode && in_byte == CH_ZERO) begin
               acc = 9'd0;
               dl  = OCT_DIGITS_ARG;
               ph  = PH_OCT;
            end else if (is_oct) begin
               acc = {6'd0, in_byte[2:0]};
               dl  = OCT_DIGITS_FMT;
               ph  = PH_OCT;
            end else if (in_byte == CH_LOWER_X) begin
               ph = PH_HEX0;
            end else if (esc[8]) begin
               em_req = 1'b1;
               em_val = esc[7:0];
            end else begin
               lst    = add_word(lst, make_word(CH_BACKSLASH, 1'b1, 1'b0, 1'b0));
               pl_req = 1'b1;
            end
         end
         PH_OCT: begin
            if (is_oct) begin
               acc = oct_acc;
               dl  = oct_dl;
               if (oct_dl == 2'd0) begin
                  em_req = 1'b1;
                  em_val = oct_acc[7:0];
               end else begin
                  ph = PH_OCT;
               end
            end else begin
               em_req = 1'b1;
               em_val = acc[7:0];
               pl_req = 1'b1;
            end
         end
         PH_HEX0: begin
            if (is_hex) begin
               acc = {5'd0, hv};
               ph  = PH_HEX1;
            end else begin
               lst    = add_word(lst, make_word(CH_BACKSLASH, 1'b1, 1'b0, 1'b1));
               lst    = add_word(lst, make_word(CH_LOWER_X, 1'b1, 1'b0, 1'b0));
               pl_req = 1'b1;
            end
         end
         PH_HEX1: begin
            em_req = 1'b1;
            if (is_hex) begin
               em_val = {acc[3:0], hv};
            end else begin
               em_val = acc[7:0];
               pl_req = 1'b1;
            end
         end
         default: begin
            ph = PH_DROP;
         end
      endcase

      // Emit a decoded value; a zero in argument mode ends the string
      if (em_req) begin
         if (argument_mode && em_val == CH_NUL) begin
            ph     = PH_DROP;
            pl_req = 1'b0;
         end else begin
            lst = add_word(lst, make_word(em_val, 1'b1, 1'b0, 1'b0));
         end
      end

      // Handle the byte as plain text
      if (pl_req) begin
         if (in_byte == CH_BACKSLASH) begin
            ph = PH_ESC;
         end else if (argument_mode && in_byte == CH_NUL) begin
            ph = PH_DROP;
         end else begin
            ph  = PH_TEXT;
            lst = add_word(lst, make_word(in_byte, 1'b1, 1'b0, 1'b0));
         end
      end

      // Flush an unfinished escape at the end of the string
      if (is_last) begin
         tail_val = acc[7:0];
         case (ph)
            PH_ESC: begin
               lst = add_word(lst, make_word(CH_BACKSLASH, 1'b1, 1'b0, 1'b0));
            end
            PH_OCT, PH_HEX1: begin
               if (!(argument_mode && tail_val == CH_NUL)) begin
                  lst = add_word(lst, make_word(tail_val, 1'b1, 1'b0, 1'b0));
               end
            end
            PH_HEX0: begin
               lst = add_word(lst, make_word(CH_BACKSLASH, 1'b1, 1'b0, 1'b1));
               lst = add_word(lst, make_word(CH_LOWER_X, 1'b1, 1'b0, 1'b0));
            end
            default: begin
            end
         endcase
         if (lst.count == 2'd0) begin
            lst = add_word(lst, make_word(8'd0, 1'b0, 1'b0, 1'b0));
         end
         lst.words[lst.count - 2'd1].end_of_string = 1'b1;
         ph  = PH_TEXT;
         acc = 9'd0;
         dl  = 2'd0;
      end else begin
         tail_val = 8'd0;
      end

      // Mark the last word of this step
      if (lst.count != 2'd0) begin
         lst.words[lst.count - 2'd1].run_last = 1'b1;
      end

      next_state.phase       = ph;
      next_state.accum_value = acc;
      next_state.digits_left = dl;
      words                  = lst;
   end

endmodule

// ----- src/bed_result_queue.sv -----
// Result queue of the escape decoder: takes up to three words a cycle,
// hands out one word a cycle while rsp is ready. Uses bed_pkg, bed_rsp_if.
module bed_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_en,
   input  bed_pkg::dec_out_type push_data,
   output logic                 space_ok,
   bed_rsp_if.source            rsp
);
   import bed_pkg::*;

   rsp_word_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic [1:0]              push_n;
   logic                    pop;
   rsp_word_type            head;

   assign push_n = push_en ? push_data.count : 2'd0;
   assign pop    = rsp.valid && rsp.ready;

   // Advance pointers and fill level
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in  = count_ff + QUEUE_CNT_W'(push_n) - QUEUE_CNT_W'(pop);
   assign space_ok  = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - RES_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the step's words at consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++) begin
         if (push_en && (2'(i) < push_data.count)) begin
            mem_ff[wr_ptr_ff + QUEUE_PTR_W'(i)] <= push_data.words[i];
         end
      end
   end

   // Present the oldest word
   assign head              = mem_ff[rd_ptr_ff];
   assign rsp.valid         = count_ff != '0;
   assign rsp.out_byte      = head.out_byte;
   assign rsp.has_byte      = head.has_byte;
   assign rsp.run_last      = head.run_last;
   assign rsp.end_of_string = head.end_of_string;
   assign rsp.stop_all      = head.stop_all;
   assign rsp.bad_hex       = head.bad_hex;

endmodule

// ----- src/backslash_escape_decoder_unit.sv -----
// Backslash escape decoder, top level.
// Usage:
//   req_if carries one raw byte of a string per word, is_last on its final
//   byte. rsp_if carries up to one decoded byte per word, with run_last on the
//   last word caused by an input word and end_of_string on the last word of
//   the string. csr_write_enable/csr_write_data set argument_mode; write it
//   only while no string is in progress and the result side has drained.
// Timing:
//   An accepted word is decoded in the same cycle against the escape state
//   and its words are written into an 8-entry result queue, whose registered
//   memory and count offer them on rsp_if. One input word per cycle is taken
//   while the queue has room for three words; since each input word yields
//   zero to three results, the sustained rate is set by the single read port
//   of the result queue: one result word per cycle while rsp_if is ready.
// Reset and stall:
//   Reset empties the queue, returns to plain text and clears argument_mode.
//   When rsp_if stalls the queue holds its words and req_if.ready drops once
//   fewer than three free slots remain; nothing is lost or repeated.
// Depends on bed_pkg, bed_req_if, bed_rsp_if, bed_decode, bed_result_queue.
module backslash_escape_decoder_unit (
   input  logic      clock,
   input  logic      reset,
   bed_req_if.sink   req_if,
   bed_rsp_if.source rsp_if,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);
   import bed_pkg::*;

   logic          argument_mode_ff, argument_mode_in;
   dec_state_type state_ff, state_in;
   dec_state_type dec_next;
   dec_out_type   dec_words;
   logic          accept;
   logic          space_ok;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = space_ok;

   // Hold the mode register unless written
   assign argument_mode_in = csr_write_enable ? csr_write_data : argument_mode_ff;

   // Advance the escape state on each accepted word
   assign state_in = accept ? dec_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         argument_mode_ff     <= 1'b0;
         state_ff.phase       <= PH_TEXT;
         state_ff.accum_value <= '0;
         state_ff.digits_left <= '0;
      end else begin
         argument_mode_ff <= argument_mode_in;
         state_ff         <= state_in;
      end
   end

   bed_decode u_decode (
      .state         (state_ff),
      .argument_mode (argument_mode_ff),
      .in_byte       (req_if.in_byte),
      .is_last       (req_if.is_last),
      .next_state    (dec_next),
      .words         (dec_words)
   );

   bed_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push_data (dec_words),
      .space_ok  (space_ok),
      .rsp       (rsp_if)
   );

endmodule

// ----- src/bed_checker.sv -----
// Port-level checks on the result channel of the escape decoder,
// bound to the top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module bed_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic       rsp_run_last,
   input logic       rsp_end_of_string,
   input logic       rsp_stop_all,
   input logic       rsp_bad_hex
);

   // A stop marker carries no character
   `BED_ASSERT_HOLD(a_stop_empty, clock, reset, rsp_valid && rsp_stop_all |-> !rsp_has_byte)

   // The end of a string closes its word's run
   `BED_ASSERT_HOLD(a_eos_run, clock, reset, rsp_valid && rsp_end_of_string |-> rsp_run_last)

   // An empty word carries a zero byte
   `BED_ASSERT_HOLD(a_empty_zero, clock, reset,
                    rsp_valid && !rsp_has_byte |-> rsp_out_byte == 8'h00)

   // A bad hex flag rides on a backslash
   `BED_ASSERT_HOLD(a_bad_hex_bs, clock, reset,
                    rsp_valid && rsp_bad_hex |-> rsp_has_byte && rsp_out_byte == 8'h5C)

   // Reset drains the result side
   `BED_ASSERT_AFTER(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind backslash_escape_decoder_unit bed_checker u_bed_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_out_byte      (rsp_if.out_byte),
   .rsp_has_byte      (rsp_if.has_byte),
   .rsp_run_last      (rsp_if.run_last),
   .rsp_end_of_string (rsp_if.end_of_string),
   .rsp_stop_all      (rsp_if.stop_all),
   .rsp_bad_hex       (rsp_if.bad_hex)
);
